/* rtl/assert_macros.svh */
// Assertion macros shared by the decoder RTL files.
// No dependencies; simulation builds get the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a clocked property, skipped while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: property violated");
// Check that a condition never holds at a clock edge
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* rtl/qsed_pkg.sv */
// Types, codes and lookup functions of the quoted string escape decoder.
// No dependencies; imported by every decoder module.
package qsed_pkg;

   // Characters with a role in the syntax
   localparam logic [15:0] QUOTE_SINGLE = 16'h0027;
   localparam logic [15:0] QUOTE_DOUBLE = 16'h0022;
   localparam logic [15:0] BACKSLASH    = 16'h005C;
   localparam logic [15:0] CHAR_LOWER_X = 16'h0078;
   localparam logic [15:0] CHAR_LOWER_U = 16'h0075;
   localparam logic [15:0] CHAR_UPPER_U = 16'h0055;

   // Status codes
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_TOO_SHORT = 4'd1;
   localparam logic [3:0] ERR_BAD_OPEN  = 4'd2;
   localparam logic [3:0] ERR_MISMATCH  = 4'd3;
   localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
   localparam logic [3:0] ERR_BAD_HEX   = 4'd5;
   localparam logic [3:0] ERR_CUT_SHORT = 4'd6;
   localparam logic [3:0] ERR_RANGE     = 4'd7;
   localparam logic [3:0] ERR_SURROGATE = 4'd8;

   // Code point limits
   localparam logic [31:0] MAX_CODE_POINT = 32'h0010FFFF;
   localparam logic [31:0] MAX_BMP        = 32'h0000FFFF;
   localparam logic [20:0] SUPP_OFFSET    = 21'h010000;
   localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
   localparam logic [15:0] SURR_LAST      = 16'hDFFF;

   // Result queue depth
   localparam int          RSP_DEPTH  = 4;
   localparam int          RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int          RSP_CNT_W  = $clog2(RSP_DEPTH + 1);
   localparam logic [RSP_CNT_W-1:0] RSP_ROOM_LIMIT = RSP_CNT_W'(RSP_DEPTH - 2);

   // Scanner state
   typedef enum logic [2:0] {
      PH_TEXT   = 3'b001,
      PH_ESCAPE = 3'b010,
      PH_HEX    = 3'b100
   } phase_type;

   // Flavor of numeric escape
   typedef enum logic [1:0] {
      HEX_X     = 2'd0,
      HEX_U     = 2'd1,
      HEX_BIG_U = 2'd2
   } hex_kind_type;

   // One result transaction
   typedef struct packed {
      logic        kind;
      logic [15:0] code_unit;
      logic [3:0]  status;
      logic        done_res;
   } result_type;

   // Results produced by one input transaction
   typedef struct packed {
      logic [1:0]  count;
      result_type  res0;
      result_type  res1;
   } dec_out_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] unit;
   } esc_map_type;

   // Value of one hex digit character
   function automatic hex_digit_type hex_digit(input logic [15:0] c);
      hex_digit_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= 16'h0030 && c <= 16'h0039) begin
         r.value = c[3:0];
      end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
         r.value = c[3:0] + 4'd9;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // Single-character escapes and the unit each one stands for
   function automatic esc_map_type esc_map(input logic [15:0] c);
      esc_map_type r;
      r.ok = 1'b1;
      case (c)
         16'h0027: r.unit = 8'h27;
         16'h0022: r.unit = 8'h22;
         16'h005C: r.unit = 8'h5C;
         16'h0030: r.unit = 8'h00;
         16'h0061: r.unit = 8'h07;
         16'h0062: r.unit = 8'h08;
         16'h0065: r.unit = 8'h1B;
         16'h0066: r.unit = 8'h0C;
         16'h006E: r.unit = 8'h0A;
         16'h0072: r.unit = 8'h0D;
         16'h0074: r.unit = 8'h09;
         16'h0076: r.unit = 8'h0B;
         default: begin
            r.ok   = 1'b0;
            r.unit = 8'h00;
         end
      endcase
      return r;
   endfunction

   // Build a decoded unit result
   function automatic result_type unit_result(input logic [15:0] u);
      result_type r;
      r.kind      = 1'b0;
      r.code_unit = u;
      r.status    = ERR_NONE;
      r.done_res  = 1'b0;
      return r;
   endfunction

   // Build a final status result
   function automatic result_type status_result(input logic [3:0] s);
      result_type r;
      r.kind      = 1'b1;
      r.code_unit = 16'h0000;
      r.status    = s;
      r.done_res  = 1'b1;
      return r;
   endfunction

endpackage

/* rtl/qsed_decoder.sv */
// Scanner state and combinational decode of one registered code unit.
// Depends on qsed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qsed_decoder
   import qsed_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic [15:0]  in_char,
   input  logic         in_last,
   output dec_out_type  dec_out
);

   logic         seen_first_ff, seen_first_in;
   logic         quote_single_ff, quote_single_in;
   phase_type    phase_ff, phase_in;
   logic [3:0]   digits_left_ff, digits_left_in;
   hex_kind_type hex_kind_ff, hex_kind_in;
   logic [31:0]  hex_accum_ff, hex_accum_in;
   logic [3:0]   err_ff, err_in;

   hex_digit_type digit;
   esc_map_type   esc;
   logic [31:0]   hex_value;
   logic [20:0]   supp_value;
   logic [15:0]   closing_quote;
   logic [3:0]    final_status;

   assign digit         = hex_digit(in_char);
   assign esc           = esc_map(in_char);
   assign hex_value     = {hex_accum_ff[27:0], digit.value};
   assign supp_value    = hex_value[20:0] - SUPP_OFFSET;
   assign closing_quote = quote_single_ff ? QUOTE_SINGLE : QUOTE_DOUBLE;

   // Pick the status for the closing unit: bad open wins, then a wrong closing quote, then the first content error
   always_comb begin
      if (err_ff == ERR_BAD_OPEN) begin
         final_status = ERR_BAD_OPEN;
      end else if (in_char != closing_quote) begin
         final_status = ERR_MISMATCH;
      end else if (err_ff != ERR_NONE) begin
         final_status = err_ff;
      end else if (phase_ff != PH_TEXT) begin
         final_status = ERR_CUT_SHORT;
      end else begin
         final_status = ERR_NONE;
      end
   end

   // Decode the current unit and advance the scanner
   always_comb begin
      seen_first_in   = seen_first_ff;
      quote_single_in = quote_single_ff;
      phase_in        = phase_ff;
      digits_left_in  = digits_left_ff;
      hex_kind_in     = hex_kind_ff;
      hex_accum_in    = hex_accum_ff;
      err_in          = err_ff;
      dec_out.count   = 2'd0;
      dec_out.res0    = unit_result(16'h0000);
      dec_out.res1    = unit_result(16'h0000);

      if (fire) begin
         if (!seen_first_ff) begin
            if (in_last) begin
               dec_out.count   = 2'd1;
               dec_out.res0    = status_result(ERR_TOO_SHORT);
               quote_single_in = 1'b0;
               phase_in        = PH_TEXT;
               err_in          = ERR_NONE;
            end else begin
               seen_first_in = 1'b1;
               if (in_char == QUOTE_SINGLE) begin
                  quote_single_in = 1'b1;
               end else if (in_char == QUOTE_DOUBLE) begin
                  quote_single_in = 1'b0;
               end else begin
                  err_in = ERR_BAD_OPEN;
               end
            end
         end else if (in_last) begin
            // Closing unit: report and return to the reset state
            dec_out.count   = 2'd1;
            dec_out.res0    = status_result(final_status);
            seen_first_in   = 1'b0;
            quote_single_in = 1'b0;
            phase_in        = PH_TEXT;
            err_in          = ERR_NONE;
         end else if (err_ff != ERR_NONE) begin
            // Drop content after an error
            dec_out.count = 2'd0;
         end else if (quote_single_ff) begin
            dec_out.count = 2'd1;
            dec_out.res0  = unit_result(in_char);
         end else begin
            case (phase_ff)
               PH_TEXT: begin
                  if (in_char == BACKSLASH) begin
                     phase_in = PH_ESCAPE;
                  end else begin
                     dec_out.count = 2'd1;
                     dec_out.res0  = unit_result(in_char);
                  end
               end
               PH_ESCAPE: begin
                  phase_in     = PH_TEXT;
                  hex_accum_in = 32'h0;
                  if (in_char == CHAR_LOWER_X) begin
                     phase_in       = PH_HEX;
                     hex_kind_in    = HEX_X;
                     digits_left_in = 4'd2;
                  end else if (in_char == CHAR_LOWER_U) begin
                     phase_in       = PH_HEX;
                     hex_kind_in    = HEX_U;
                     digits_left_in = 4'd4;
                  end else if (in_char == CHAR_UPPER_U) begin
                     phase_in       = PH_HEX;
                     hex_kind_in    = HEX_BIG_U;
                     digits_left_in = 4'd8;
                  end else if (esc.ok) begin
                     dec_out.count = 2'd1;
                     dec_out.res0  = unit_result({8'h00, esc.unit});
                  end else begin
                     err_in = ERR_BAD_ESC;
                  end
               end
               PH_HEX: begin
                  if (!digit.ok) begin
                     err_in   = ERR_BAD_HEX;
                     phase_in = PH_TEXT;
                  end else begin
                     hex_accum_in   = hex_value;
                     digits_left_in = digits_left_ff - 4'd1;
                     if (digits_left_ff == 4'd1) begin
                        // Last digit: emit the value or flag it
                        phase_in = PH_TEXT;
                        if (hex_kind_ff != HEX_BIG_U) begin
                           dec_out.count = 2'd1;
                           dec_out.res0  = unit_result(hex_value[15:0]);
                        end else if (hex_value > MAX_CODE_POINT) begin
                           err_in = ERR_RANGE;
                        end else if (hex_value > MAX_BMP) begin
                           dec_out.count = 2'd2;
                           dec_out.res0  = unit_result(HIGH_SURR_BASE
                                                       + {6'b0, supp_value[19:10]});
                           dec_out.res1  = unit_result(LOW_SURR_BASE
                                                       + {6'b0, supp_value[9:0]});
                        end else if (hex_value[15:0] >= HIGH_SURR_BASE
                                     && hex_value[15:0] <= SURR_LAST) begin
                           err_in = ERR_SURROGATE;
                        end else begin
                           dec_out.count = 2'd1;
                           dec_out.res0  = unit_result(hex_value[15:0]);
                        end
                     end
                  end
               end
               default: begin
                  phase_in = PH_TEXT;
               end
            endcase
         end
      end
   end

   // Hold control state, clear it on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_first_ff   <= 1'b0;
         quote_single_ff <= 1'b0;
         phase_ff        <= PH_TEXT;
         err_ff          <= ERR_NONE;
      end else begin
         seen_first_ff   <= seen_first_in;
         quote_single_ff <= quote_single_in;
         phase_ff        <= phase_in;
         err_ff          <= err_in;
      end
   end

   // Numeric escape registers, not reset: loaded at each escape start and updated per digit
   always_ff @(posedge clock) begin
      digits_left_ff <= digits_left_in;
      hex_kind_ff    <= hex_kind_in;
      hex_accum_ff   <= hex_accum_in;
   end

   `ASSERT_CLK(a_clear_after_status, clock, reset, (fire && in_last) |=> (!seen_first_ff && err_ff == ERR_NONE && phase_ff == PH_TEXT))
   `ASSERT_CLK(a_pair_is_surrogate, clock, reset, (dec_out.count == 2'd2) |-> (dec_out.res0.code_unit[15:10] == 6'b110110 && dec_out.res1.code_unit[15:10] == 6'b110111))
   `ASSERT_CLK(a_quiet_after_error, clock, reset, (fire && seen_first_ff && !in_last && err_ff != ERR_NONE) |-> (dec_out.count == 2'd0))

endmodule

/* rtl/qsed_rsp_fifo.sv */
// Result queue: takes up to two results a cycle, hands one out per transaction.
// Depends on qsed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qsed_rsp_fifo
   import qsed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dec_out_type push,
   output logic        room,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_data
);

   result_type             entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_PTR_W-1:0]   wr_next;
   logic                   pop;
   logic [RSP_CNT_W-1:0]   count_after_pop;

   assign out_valid       = (count_ff != '0);
   assign out_data        = entry_ff[rd_ptr_ff];
   assign pop             = out_valid && out_ready;
   assign count_after_pop = count_ff - RSP_CNT_W'(pop);
   // Room for a full two-result push
   assign room            = (count_after_pop <= RSP_ROOM_LIMIT);
   assign wr_next         = wr_ptr_ff + RSP_PTR_W'(1);

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_after_pop + RSP_CNT_W'(push.count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the new results
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.res1;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, count_ff > RSP_CNT_W'(RSP_DEPTH))

endmodule

/* rtl/quoted_string_escape_decoder.sv */
// Quoted string escape decoder: one UTF-16 code unit per cycle in, while the
// result queue has room. A result passes through the input register and the
// result queue; a \U escape above the BMP gives two results, pushed together.
// Throughput bounded by the one-result-per-cycle output port while rsp_tready is high.
// Reset (synchronous, active high) clears scanner control state and empties the queue.
// Depends on qsed_pkg, qsed_decoder and qsed_rsp_fifo.

module quoted_string_escape_decoder
   import qsed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] char_in
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] code_unit, [19:16] status, [23:20] zero
   output logic        rsp_tlast,   // done_res
   output logic        rsp_tuser    // kind
);

   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_char_ff;
   logic        in_last_ff;
   logic        room;
   logic        fire;
   logic        req_accept;
   dec_out_type dec_out;
   result_type  head;

   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   // Input register: load on accept, drain when decoded
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   qsed_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_char (in_char_ff),
      .in_last (in_last_ff),
      .dec_out (dec_out)
   );

   qsed_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (dec_out),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   // Pack the result transaction
   assign rsp_tdata = {4'b0000, head.status, head.code_unit};
   assign rsp_tlast = head.done_res;
   assign rsp_tuser = head.kind;

endmodule

/* bench/quoted_string_escape_decoder_tb.sv */
`timescale 1ns / 100ps
// Testbench for quoted_string_escape_decoder: directed strings, then random quoted strings
// whose decoded units and status are predicted in a scoreboard class and checked in order.
// Depends on qsed_pkg and the quoted_string_escape_decoder RTL.

module quoted_string_escape_decoder_tb;
   import qsed_pkg::*;

   localparam int ITEM_TARGET  = 1150;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 90;

   // Letters that follow a backslash
   localparam logic [15:0] CH_ZERO    = 16'h0030;
   localparam logic [15:0] CH_LOWER_A = 16'h0061;
   localparam logic [15:0] CH_LOWER_B = 16'h0062;
   localparam logic [15:0] CH_LOWER_E = 16'h0065;
   localparam logic [15:0] CH_LOWER_F = 16'h0066;
   localparam logic [15:0] CH_LOWER_N = 16'h006E;
   localparam logic [15:0] CH_LOWER_R = 16'h0072;
   localparam logic [15:0] CH_LOWER_T = 16'h0074;
   localparam logic [15:0] CH_LOWER_V = 16'h0076;
   localparam logic [15:0] CH_LOWER_Q = 16'h0071;

   // Predicts the result transactions of each input transaction and checks them
   class decode_scoreboard;
      result_type   expected_q[$];
      int           mismatches;
      int           units_checked;
      int           status_count[16];
      bit           seen_first;
      bit           single_quoted;
      phase_type    scan_phase;
      hex_kind_type hex_flavor;
      int           digits_left;
      logic [31:0]  accum;
      logic [3:0]   error_code;

      function new();
         mismatches    = 0;
         units_checked = 0;
         foreach (status_count[i]) status_count[i] = 0;
         clear_string();
      endfunction

      // Return to the idle state between strings
      function void clear_string();
         seen_first    = 1'b0;
         single_quoted = 1'b0;
         scan_phase    = PH_TEXT;
         hex_flavor    = HEX_X;
         digits_left   = 0;
         accum         = '0;
         error_code    = ERR_NONE;
      endfunction

      function void push_unit(logic [15:0] u);
         result_type r;
         r.kind      = 1'b0;
         r.code_unit = u;
         r.status    = ERR_NONE;
         r.done_res  = 1'b0;
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void push_status(logic [3:0] s);
         result_type r;
         r.kind      = 1'b1;
         r.code_unit = 16'h0000;
         r.status    = s;
         r.done_res  = 1'b1;
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void open_hex(hex_kind_type flavor, int digits);
         scan_phase  = PH_HEX;
         hex_flavor  = flavor;
         digits_left = digits;
         accum       = '0;
      endfunction

      // Unit named by a one-letter escape; bit 16 clear when the letter names none
      function logic [16:0] simple_escape(logic [15:0] letter);
         case (letter)
            QUOTE_SINGLE: return {1'b1, QUOTE_SINGLE};
            QUOTE_DOUBLE: return {1'b1, QUOTE_DOUBLE};
            BACKSLASH:    return {1'b1, BACKSLASH};
            CH_ZERO:      return 17'h1_0000;
            CH_LOWER_A:   return 17'h1_0007;
            CH_LOWER_B:   return 17'h1_0008;
            CH_LOWER_E:   return 17'h1_001B;
            CH_LOWER_F:   return 17'h1_000C;
            CH_LOWER_N:   return 17'h1_000A;
            CH_LOWER_R:   return 17'h1_000D;
            CH_LOWER_T:   return 17'h1_0009;
            CH_LOWER_V:   return 17'h1_000B;
            default:      return 17'h0_0000;
         endcase
      endfunction

      // Advance the decoder state by one accepted input transaction
      function void note_input(logic [15:0] c, bit last);
         int          digit;
         logic [31:0] w;
         logic [16:0] esc;
         logic [15:0] closing;
         logic [3:0]  s;
         if (!seen_first) begin
            if (last) begin
               push_status(ERR_TOO_SHORT);
               clear_string();
            end else begin
               seen_first = 1'b1;
               if (c == QUOTE_SINGLE) single_quoted = 1'b1;
               else if (c != QUOTE_DOUBLE) error_code = ERR_BAD_OPEN;
            end
         end else if (last) begin
            // bad open wins, then a wrong closing quote, then the first content error
            closing = single_quoted ? QUOTE_SINGLE : QUOTE_DOUBLE;
            if (error_code == ERR_BAD_OPEN) s = ERR_BAD_OPEN;
            else if (c != closing) s = ERR_MISMATCH;
            else if (error_code != ERR_NONE) s = error_code;
            else if (scan_phase != PH_TEXT) s = ERR_CUT_SHORT;
            else s = ERR_NONE;
            push_status(s);
            clear_string();
         end else if (error_code == ERR_NONE) begin
            if (single_quoted) begin
               push_unit(c);
            end else begin
               case (scan_phase)
                  PH_TEXT: begin
                     if (c == BACKSLASH) scan_phase = PH_ESCAPE;
                     else push_unit(c);
                  end
                  PH_ESCAPE: begin
                     scan_phase = PH_TEXT;
                     if (c == CHAR_LOWER_X) open_hex(HEX_X, 2);
                     else if (c == CHAR_LOWER_U) open_hex(HEX_U, 4);
                     else if (c == CHAR_UPPER_U) open_hex(HEX_BIG_U, 8);
                     else begin
                        esc = simple_escape(c);
                        if (esc[16]) push_unit(esc[15:0]);
                        else error_code = ERR_BAD_ESC;
                     end
                  end
                  default: begin
                     // hex digits: 0-9, a-f, A-F
                     if (c >= 16'h0030 && c <= 16'h0039) digit = c - 16'h0030;
                     else if (c >= 16'h0061 && c <= 16'h0066) digit = c - 16'h0057;
                     else if (c >= 16'h0041 && c <= 16'h0046) digit = c - 16'h0037;
                     else digit = -1;
                     if (digit < 0) begin
                        error_code = ERR_BAD_HEX;
                        scan_phase = PH_TEXT;
                     end else begin
                        accum = {accum[27:0], digit[3:0]};
                        digits_left--;
                        if (digits_left == 0) begin
                           scan_phase = PH_TEXT;
                           if (hex_flavor != HEX_BIG_U) begin
                              push_unit(accum[15:0]);
                           end else if (accum > MAX_CODE_POINT) begin
                              error_code = ERR_RANGE;
                           end else if (accum > MAX_BMP) begin
                              // split into a surrogate pair
                              w = accum - 32'(SUPP_OFFSET);
                              push_unit(HIGH_SURR_BASE + {6'b0, w[19:10]});
                              push_unit(LOW_SURR_BASE + {6'b0, w[9:0]});
                           end else if (accum >= HIGH_SURR_BASE && accum <= SURR_LAST) begin
                              error_code = ERR_SURROGATE;
                           end else begin
                              push_unit(accum[15:0]);
                           end
                        end
                     end
                  end
               endcase
            end
         end
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // Check one accepted result transaction against the oldest expectation
      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got kind %b unit %h status %0d last %b",
                     $time, got.kind, got.code_unit, got.status, got.done_res);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("kind", 16'(want.kind), 16'(got.kind));
         compare_field("code_unit", want.code_unit, got.code_unit);
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
         if (want.kind) status_count[want.status]++;
         else units_checked++;
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] char_in
   logic        req_tlast  = 1'b0; // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] code_unit, [19:16] status, [23:20] zero
   logic        rsp_tlast;         // done_res
   logic        rsp_tuser;         // kind

   decode_scoreboard board;
   logic [15:0] text_q[$];
   logic [15:0] escape_letters[$];
   int          items_sent   = 0;
   int          strings_sent = 0;
   int          burst_left   = 0;
   int          cycle_count  = 0;
   int          hold_left    = 0;
   bit          gaps_on      = 1'b0;
   logic        hold_request = 1'b0;
   logic        hold_taken   = 1'b0;
   logic [1:0]  stall_mode   = 2'd0;

   quoted_string_escape_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Drive the result side: one long hold-off on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (cycle_count[7:0] == 8'd0) stall_mode <= 2'($urandom_range(0, 2));
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= ($urandom_range(0, 2) != 0);
            default: rsp_tready <= (cycle_count[3:0] < 4'd10);
         endcase
      end
   end

   // Collect each accepted result transaction
   always @(posedge clock) begin : result_monitor
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind      = rsp_tuser;
         got.code_unit = rsp_tdata[15:0];
         got.status    = rsp_tdata[19:16];
         got.done_res  = rsp_tlast;
         board.check_result(got);
      end
   end

   function automatic logic [15:0] rand_unit();
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(16'h0020, 16'h007E));
      return 16'($urandom);
   endfunction

   // Add one unit to the end of the string being built
   function automatic void append_unit(input logic [15:0] c);
      text_q.insert(text_q.size(), c);
   endfunction

   // Offer one unit, wait for its transaction, then maybe pause between bursts
   task automatic send_unit(input logic [15:0] c, input bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_input(c, last);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         if (gaps_on) begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_unit(text_q[i], i == text_q.size() - 1);
      strings_sent++;
   endtask

   // Append the low digits of a value as hex characters, case chosen at random
   task automatic push_hex(input logic [31:0] value, input int digits);
      logic [3:0] d;
      for (int i = digits - 1; i >= 0; i--) begin
         d = value[i*4 +: 4];
         if (d < 4'd10) append_unit(16'h0030 + 16'(d));
         else if ($urandom_range(0, 1) == 0) append_unit(16'h0037 + 16'(d));
         else append_unit(16'h0057 + 16'(d));
      end
   endtask

   // Build one random string: mostly well-formed, some broken
   task automatic build_random_text();
      int          pick;
      int          n_elems;
      logic [15:0] open_quote;
      logic [31:0] value;
      text_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         append_unit(rand_unit());
         return;
      end
      open_quote = (pick < 16) ? QUOTE_SINGLE : QUOTE_DOUBLE;
      if (pick >= 16 && pick < 20) append_unit(16'($urandom));
      else append_unit(open_quote);
      n_elems = $urandom_range(0, 8);
      repeat (n_elems) begin
         pick = $urandom_range(0, 99);
         if (open_quote == QUOTE_SINGLE || pick < 30) begin
            append_unit(rand_unit());
         end else if (pick < 50) begin
            append_unit(BACKSLASH);
            append_unit(escape_letters[$urandom_range(0, escape_letters.size() - 1)]);
         end else if (pick < 58) begin
            append_unit(BACKSLASH);
            append_unit(CHAR_LOWER_X);
            push_hex($urandom, 2);
         end else if (pick < 68) begin
            append_unit(BACKSLASH);
            append_unit(CHAR_LOWER_U);
            push_hex($urandom, 4);
         end else if (pick < 92) begin
            case ($urandom_range(0, 9))
               0:       value = MAX_CODE_POINT;
               1:       value = 32'(SUPP_OFFSET);
               2:       value = MAX_CODE_POINT + 32'd1 + $urandom_range(0, 1000);
               3:       value = $urandom;
               4:       value = $urandom_range(HIGH_SURR_BASE, SURR_LAST);
               5:       value = $urandom_range(0, MAX_BMP);
               6:       value = ($urandom_range(0, 1) == 0) ? MAX_BMP : 32'd0;
               default: value = $urandom_range(32'(SUPP_OFFSET), MAX_CODE_POINT);
            endcase
            append_unit(BACKSLASH);
            append_unit(CHAR_UPPER_U);
            push_hex(value, 8);
         end else if (pick < 96) begin
            append_unit(BACKSLASH);
            append_unit(16'($urandom));
         end else begin
            // hex escape broken by a random character
            append_unit(BACKSLASH);
            append_unit(CHAR_LOWER_U);
            push_hex($urandom, $urandom_range(0, 3));
            append_unit(16'($urandom));
         end
      end
      // leave an escape open at the end now and then
      if (open_quote == QUOTE_DOUBLE && $urandom_range(0, 19) == 0) begin
         append_unit(BACKSLASH);
         if ($urandom_range(0, 1) == 0) begin
            append_unit(CHAR_UPPER_U);
            push_hex($urandom, $urandom_range(0, 7));
         end
      end
      if ($urandom_range(0, 24) == 0) append_unit(16'($urandom));
      else append_unit(open_quote);
   endtask

   initial begin
      int no_gap_strings;
      no_gap_strings = 0;
      board = new();
      escape_letters = '{QUOTE_SINGLE, QUOTE_DOUBLE, BACKSLASH, CH_ZERO, CH_LOWER_A, CH_LOWER_B,
                         CH_LOWER_E, CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T, CH_LOWER_V};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: lone unit, bad opening, raw extremes, bad escape, bad hex, open escape, mismatch
      text_q = '{QUOTE_DOUBLE};
      send_text();
      text_q = '{16'hFFFF, QUOTE_DOUBLE};
      send_text();
      text_q = '{QUOTE_SINGLE, 16'h0000, 16'hFFFF, BACKSLASH, QUOTE_SINGLE};
      send_text();
      text_q = '{QUOTE_DOUBLE, BACKSLASH, CH_LOWER_Q, QUOTE_DOUBLE};
      send_text();
      text_q = '{QUOTE_DOUBLE, BACKSLASH, CHAR_LOWER_X, 16'h0046, 16'h0067, QUOTE_DOUBLE};
      send_text();
      text_q = '{QUOTE_DOUBLE, BACKSLASH, QUOTE_DOUBLE};
      send_text();
      text_q = '{QUOTE_DOUBLE, CH_LOWER_A, QUOTE_SINGLE};
      send_text();

      // Random strings; once, keep offering while the result side holds off
      gaps_on = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 300 && !hold_request) begin
            hold_request <= 1'b1;
            no_gap_strings = 8;
         end
         if (no_gap_strings > 0) begin
            gaps_on = 1'b0;
            no_gap_strings--;
         end else if ($urandom_range(0, 9) == 0) begin
            gaps_on = !gaps_on;
         end
         build_random_text();
         send_text();
      end
      req_tvalid <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d strings, %0d units in, %0d decoded units checked", strings_sent,
               items_sent, board.units_checked);
      $display("tb: status ok %0d, short %0d, open %0d, mismatch %0d, escape %0d,",
               board.status_count[ERR_NONE], board.status_count[ERR_TOO_SHORT],
               board.status_count[ERR_BAD_OPEN], board.status_count[ERR_MISMATCH],
               board.status_count[ERR_BAD_ESC]);
      $display("tb: status hex %0d, cut %0d, range %0d, surrogate %0d",
               board.status_count[ERR_BAD_HEX], board.status_count[ERR_CUT_SHORT],
               board.status_count[ERR_RANGE], board.status_count[ERR_SURROGATE]);
      if (board.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qsed_pkg.sv
rtl/qsed_decoder.sv
rtl/qsed_rsp_fifo.sv
rtl/quoted_string_escape_decoder.sv
bench/quoted_string_escape_decoder_tb.sv
